>>> design/rhcc_pkg.sv
package rhcc_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W  = 11;
  localparam int QUO_W  = 10;
  localparam int NUM_W  = 17;

  // commands
  localparam logic CMD_RGB2HSV = 1'b0;
  localparam logic CMD_HSV2RGB = 1'b1;

  // which channel holds the maximum
  localparam logic [1:0] MAXCH_RED   = 2'd0;
  localparam logic [1:0] MAXCH_GREEN = 2'd1;
  localparam logic [1:0] MAXCH_BLUE  = 2'd2;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
  localparam logic [15:0]       MS_CONST  = 16'd65280;   // chan max times sector steps
  localparam logic [23:0]       HALF_MS   = 24'd32640;
  localparam logic [HUE_W-1:0]  HUE_TURN  = 11'd1536;
  localparam logic [HUE_W-1:0]  BASE_RED  = 11'd1280;
  localparam logic [HUE_W-1:0]  BASE_GRN  = 11'd256;
  localparam logic [HUE_W-1:0]  BASE_BLU  = 11'd768;

  typedef struct packed {
    logic              command;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [HUE_W-1:0]  hue_in;
    logic [CHAN_W-1:0] sat_in;
    logic [CHAN_W-1:0] val_in;
  } rhcc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [HUE_W-1:0]  hue_out;
    logic [CHAN_W-1:0] sat_out;
    logic [CHAN_W-1:0] val_out;
  } rhcc_out_t;

  // floor(z / 255), exact for z up to 65279
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] z);
    logic [16:0] acc;
    acc = 17'(z) + 17'(z[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

endpackage

>>> design/rhcc_div.sv
// restoring divider, three register stages, quotient bits 4 + 3 + 3
module rhcc_div (
  input  logic                           clk,
  input  logic [rhcc_pkg::NUM_W-1:0]     num,
  input  logic [rhcc_pkg::CHAN_W-1:0]    den,
  output logic [rhcc_pkg::QUO_W-1:0]     quo
);

  logic [17:0] rem_a;
  logic [17:0] trial_a;
  logic [3:0]  q_a;
  logic [13:0] rem_b;
  logic [13:0] trial_b;
  logic [2:0]  q_b;
  logic [10:0] rem_c;
  logic [10:0] trial_c;
  logic [2:0]  q_c;

  logic [13:0] a_rem_nxt, a_rem_r;
  logic [7:0]  a_den_r;
  logic [3:0]  a_quo_nxt, a_quo_r;
  logic [10:0] b_rem_nxt, b_rem_r;
  logic [7:0]  b_den_r;
  logic [6:0]  b_quo_nxt, b_quo_r;
  logic [9:0]  c_quo_nxt, c_quo_r;

  // quotient bits 9..6
  always_comb begin
    rem_a   = {1'b0, num};
    q_a     = '0;
    trial_a = '0;
    for (int i = 0; i < 4; i++) begin
      trial_a = {10'b0, den} << (9 - i);
      if (rem_a >= trial_a) begin
        rem_a      = rem_a - trial_a;
        q_a[3 - i] = 1'b1;
      end
    end
    a_rem_nxt = rem_a[13:0];
    a_quo_nxt = q_a;
  end

  // quotient bits 5..3
  always_comb begin
    rem_b   = a_rem_r;
    q_b     = '0;
    trial_b = '0;
    for (int i = 0; i < 3; i++) begin
      trial_b = {6'b0, a_den_r} << (5 - i);
      if (rem_b >= trial_b) begin
        rem_b      = rem_b - trial_b;
        q_b[2 - i] = 1'b1;
      end
    end
    b_rem_nxt = rem_b[10:0];
    b_quo_nxt = {a_quo_r, q_b};
  end

  // quotient bits 2..0
  always_comb begin
    rem_c   = b_rem_r;
    q_c     = '0;
    trial_c = '0;
    for (int i = 0; i < 3; i++) begin
      trial_c = {3'b0, b_den_r} << (2 - i);
      if (rem_c >= trial_c) begin
        rem_c      = rem_c - trial_c;
        q_c[2 - i] = 1'b1;
      end
    end
    c_quo_nxt = {b_quo_r, q_c};
  end

  always_ff @(posedge clk) begin
    a_rem_r <= a_rem_nxt;
    a_den_r <= den;
    a_quo_r <= a_quo_nxt;
    b_rem_r <= b_rem_nxt;
    b_den_r <= a_den_r;
    b_quo_r <= b_quo_nxt;
    c_quo_r <= c_quo_nxt;
  end

  assign quo = c_quo_r;

endmodule

>>> design/rgb_hsv_color_converter_top.sv
// path: a word taken at a clock edge passes the stage 1 to 4 registers and the output register
//   before it is on the result ports for the receiver to take
// throughput: one word per cycle, busy never rises; five register stages, the
//   rgb to hsv quotients go through two 3-stage restoring dividers
// reset: synchronous active-low rst_n clears the valid chain only, words in flight are dropped
// the receiver cannot stall: out_valid is a one-cycle strobe per word
module rgb_hsv_color_converter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rhcc_pkg::rhcc_in_t  in_word,
  output logic                out_valid,
  output rhcc_pkg::rhcc_out_t out_word
);

  // ---------------------------------------------------------------
  // valid and command chain, one bit per stage
  // ---------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_valid_r;
  logic s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r;

  // ---------------------------------------------------------------
  // stage 1: sort channels, wrap hue, first products
  // ---------------------------------------------------------------
  logic [1:0]  maxch;
  logic [7:0]  mx, mn, mn_rg, chroma;
  logic [9:0]  diff_e;
  logic [10:0] hue_wrap;
  logic [7:0]  frac;

  logic [7:0]  s1_mx_nxt, s1_mx_r;
  logic [7:0]  s1_c_nxt, s1_c_r;
  logic [8:0]  s1_e_nxt, s1_e_r;
  logic [1:0]  s1_maxch_r;
  logic [2:0]  s1_sec_nxt, s1_sec_r;
  logic [15:0] s1_sf_nxt, s1_sf_r;
  logic [15:0] s1_pprod_nxt, s1_pprod_r;
  logic [7:0]  s1_v_r, s1_s_r;

  always_comb begin
    // ties go to red first, then green
    if (in_word.red_in >= in_word.green_in && in_word.red_in >= in_word.blue_in) begin
      maxch = rhcc_pkg::MAXCH_RED;
    end else if (in_word.green_in >= in_word.blue_in) begin
      maxch = rhcc_pkg::MAXCH_GREEN;
    end else begin
      maxch = rhcc_pkg::MAXCH_BLUE;
    end

    mn_rg  = (in_word.red_in <= in_word.green_in) ? in_word.red_in : in_word.green_in;
    mn     = (mn_rg <= in_word.blue_in) ? mn_rg : in_word.blue_in;

    case (maxch)
      rhcc_pkg::MAXCH_RED:   mx = in_word.red_in;
      rhcc_pkg::MAXCH_GREEN: mx = in_word.green_in;
      default:               mx = in_word.blue_in;
    endcase
    chroma = mx - mn;

    // channel difference offset by chroma, lands in 0 .. 2*chroma
    case (maxch)
      rhcc_pkg::MAXCH_RED:
        diff_e = 10'(in_word.green_in) - 10'(in_word.blue_in) + 10'(chroma);
      rhcc_pkg::MAXCH_GREEN:
        diff_e = 10'(in_word.blue_in) - 10'(in_word.red_in) + 10'(chroma);
      default:
        diff_e = 10'(in_word.red_in) - 10'(in_word.green_in) + 10'(chroma);
    endcase

    s1_mx_nxt = mx;
    s1_c_nxt  = chroma;
    s1_e_nxt  = diff_e[8:0];

    // a full turn has the same low bits, only the sector needs the wrap
    hue_wrap = (in_word.hue_in >= rhcc_pkg::HUE_TURN) ?
               (in_word.hue_in - rhcc_pkg::HUE_TURN) : in_word.hue_in;
    frac     = in_word.hue_in[7:0];

    s1_sec_nxt   = hue_wrap[10:8];
    s1_sf_nxt    = 16'(in_word.sat_in) * 16'(frac);
    s1_pprod_nxt = 16'(in_word.val_in) * 16'(rhcc_pkg::CHAN_MAX - in_word.sat_in);
  end

  // ---------------------------------------------------------------
  // rgb to hsv: hue fraction and saturation quotients
  // ---------------------------------------------------------------
  logic [16:0] hue_num, sat_num;
  logic [9:0]  hue_quo, sat_quo;

  // round(256*e/c) and round(255*c/max), ties up
  assign hue_num = {s1_e_r, 8'h00} + 17'(s1_c_r >> 1);
  assign sat_num = {1'b0, s1_c_r, 8'h00} - 17'(s1_c_r) + 17'(s1_mx_r >> 1);

  rhcc_div u_hue_div (
    .clk (clk),
    .num (hue_num),
    .den (s1_c_r),
    .quo (hue_quo)
  );

  rhcc_div u_sat_div (
    .clk (clk),
    .num (sat_num),
    .den (s1_mx_r),
    .quo (sat_quo)
  );

  // rgb side fields that ride along with the divider stages
  logic [7:0] s2_mx_r, s3_mx_r, s4_mx_r;
  logic       s2_cz_r, s3_cz_r, s4_cz_r;
  logic [1:0] s2_maxch_r, s3_maxch_r, s4_maxch_r;

  // ---------------------------------------------------------------
  // hsv to rgb, stage 2: second products and p
  // ---------------------------------------------------------------
  logic [15:0] q_mul, t_mul;
  logic [23:0] s2_qnum_nxt, s2_qnum_r;
  logic [23:0] s2_tnum_nxt, s2_tnum_r;
  logic [7:0]  s2_p_nxt, s2_p_r;
  logic [7:0]  s2_v_r;
  logic [2:0]  s2_sec_r;

  always_comb begin
    // s*(256-f) never exceeds MS, so the 16-bit wrap is exact
    q_mul       = rhcc_pkg::MS_CONST - s1_sf_r;
    t_mul       = rhcc_pkg::MS_CONST - {s1_s_r, 8'h00} + s1_sf_r;
    s2_qnum_nxt = 24'(s1_v_r) * 24'(q_mul);
    s2_tnum_nxt = 24'(s1_v_r) * 24'(t_mul);
    s2_p_nxt    = rhcc_pkg::div255(s1_pprod_r + 16'd127);
  end

  // ---------------------------------------------------------------
  // hsv to rgb, stage 3: divide by 65280 as shift then divide by 255
  // ---------------------------------------------------------------
  logic [23:0] q_sum, t_sum;
  logic [7:0]  s3_q_nxt, s3_q_r, s3_t_nxt, s3_t_r;
  logic [7:0]  s3_p_r, s3_v_r;
  logic [2:0]  s3_sec_r;

  always_comb begin
    q_sum    = s2_qnum_r + rhcc_pkg::HALF_MS;
    t_sum    = s2_tnum_r + rhcc_pkg::HALF_MS;
    s3_q_nxt = rhcc_pkg::div255(q_sum[23:8]);
    s3_t_nxt = rhcc_pkg::div255(t_sum[23:8]);
  end

  // stage 4 just holds the hsv side while the dividers finish
  logic [7:0] s4_p_r, s4_q_r, s4_t_r, s4_v_r;
  logic [2:0] s4_sec_r;

  // ---------------------------------------------------------------
  // stage 5: sector select, hue offset and wrap, output word
  // ---------------------------------------------------------------
  logic [10:0]         hue_base, hue_sum, hue_fin;
  rhcc_pkg::rhcc_out_t out_word_nxt, out_word_r;

  always_comb begin
    case (s4_maxch_r)
      rhcc_pkg::MAXCH_RED:   hue_base = rhcc_pkg::BASE_RED;
      rhcc_pkg::MAXCH_GREEN: hue_base = rhcc_pkg::BASE_GRN;
      default:               hue_base = rhcc_pkg::BASE_BLU;
    endcase
    hue_sum = hue_base + 11'(hue_quo);
    hue_fin = (hue_sum >= rhcc_pkg::HUE_TURN) ? (hue_sum - rhcc_pkg::HUE_TURN) : hue_sum;

    out_word_nxt = '0;
    if (s4_cmd_r == rhcc_pkg::CMD_HSV2RGB) begin
      case (s4_sec_r)
        3'd0: begin
          out_word_nxt.red_out   = s4_v_r;
          out_word_nxt.green_out = s4_t_r;
          out_word_nxt.blue_out  = s4_p_r;
        end
        3'd1: begin
          out_word_nxt.red_out   = s4_q_r;
          out_word_nxt.green_out = s4_v_r;
          out_word_nxt.blue_out  = s4_p_r;
        end
        3'd2: begin
          out_word_nxt.red_out   = s4_p_r;
          out_word_nxt.green_out = s4_v_r;
          out_word_nxt.blue_out  = s4_t_r;
        end
        3'd3: begin
          out_word_nxt.red_out   = s4_p_r;
          out_word_nxt.green_out = s4_q_r;
          out_word_nxt.blue_out  = s4_v_r;
        end
        3'd4: begin
          out_word_nxt.red_out   = s4_t_r;
          out_word_nxt.green_out = s4_p_r;
          out_word_nxt.blue_out  = s4_v_r;
        end
        default: begin
          out_word_nxt.red_out   = s4_v_r;
          out_word_nxt.green_out = s4_p_r;
          out_word_nxt.blue_out  = s4_q_r;
        end
      endcase
    end else begin
      // grey gives hue 0, black gives saturation 0
      out_word_nxt.hue_out = s4_cz_r ? 11'd0 : hue_fin;
      out_word_nxt.sat_out = (s4_mx_r == 8'd0) ? 8'd0 : sat_quo[7:0];
      out_word_nxt.val_out = s4_mx_r;
    end
  end

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= start && !busy;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s1_cmd_r     <= in_word.command;
    s1_mx_r      <= s1_mx_nxt;
    s1_c_r       <= s1_c_nxt;
    s1_e_r       <= s1_e_nxt;
    s1_maxch_r   <= maxch;
    s1_sec_r     <= s1_sec_nxt;
    s1_sf_r      <= s1_sf_nxt;
    s1_pprod_r   <= s1_pprod_nxt;
    s1_v_r       <= in_word.val_in;
    s1_s_r       <= in_word.sat_in;

    s2_cmd_r     <= s1_cmd_r;
    s2_mx_r      <= s1_mx_r;
    s2_cz_r      <= (s1_c_r == 8'd0);
    s2_maxch_r   <= s1_maxch_r;
    s2_qnum_r    <= s2_qnum_nxt;
    s2_tnum_r    <= s2_tnum_nxt;
    s2_p_r       <= s2_p_nxt;
    s2_v_r       <= s1_v_r;
    s2_sec_r     <= s1_sec_r;

    s3_cmd_r     <= s2_cmd_r;
    s3_mx_r      <= s2_mx_r;
    s3_cz_r      <= s2_cz_r;
    s3_maxch_r   <= s2_maxch_r;
    s3_q_r       <= s3_q_nxt;
    s3_t_r       <= s3_t_nxt;
    s3_p_r       <= s2_p_r;
    s3_v_r       <= s2_v_r;
    s3_sec_r     <= s2_sec_r;

    s4_cmd_r     <= s3_cmd_r;
    s4_mx_r      <= s3_mx_r;
    s4_cz_r      <= s3_cz_r;
    s4_maxch_r   <= s3_maxch_r;
    s4_q_r       <= s3_q_r;
    s4_t_r       <= s3_t_r;
    s4_p_r       <= s3_p_r;
    s4_v_r       <= s3_v_r;
    s4_sec_r     <= s3_sec_r;

    out_word_r   <= out_word_nxt;
  end

  // the pipeline never holds, so a new word is always welcome
  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> design/rhcc_checker.sv
module rhcc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input rhcc_pkg::rhcc_in_t  in_word,
  input logic                out_valid,
  input rhcc_pkg::rhcc_out_t out_word
);

  // every accepted word comes out as an out_valid strobe
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted word did not come out");

  // no strobe without a matching word accepted earlier
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 5))
    else $error("result without an accepted word");

  // hsv to rgb leaves the hsv fields at zero
  a_hsv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_word.command == rhcc_pkg::CMD_HSV2RGB, 5)) |->
      (out_word.hue_out == 11'd0 && out_word.sat_out == 8'd0 && out_word.val_out == 8'd0))
    else $error("hsv fields not zero for hsv to rgb");

  // rgb to hsv: value is no smaller than any channel, red and blue fields zero
  a_val_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_word.command == rhcc_pkg::CMD_RGB2HSV, 5)) |->
      (out_word.val_out >= $past(in_word.red_in, 5) &&
       out_word.val_out >= $past(in_word.green_in, 5) &&
       out_word.val_out >= $past(in_word.blue_in, 5) &&
       out_word.red_out == 8'd0 && out_word.blue_out == 8'd0))
    else $error("value is not the channel maximum");

endmodule

bind rgb_hsv_color_converter_top rhcc_checker u_rhcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

>>> bench/tb_rgb_hsv_color_converter_top.sv
module tb_rgb_hsv_color_converter_top;

  // field widths of the converter
  localparam int CHAN_W = rhcc_pkg::CHAN_W;
  localparam int HUE_W  = rhcc_pkg::HUE_W;

  // fixed-point scales of the converter
  localparam longint unsigned CHAN_FULL  = 255;
  localparam longint unsigned HUE_STEPS  = 256;
  localparam longint unsigned TURN_STEPS = 6 * HUE_STEPS;
  localparam int              RANDOM_WORDS = 950;

  // one row of the directed part: the word, and a typed-in result where it is obvious
  typedef struct {
    rhcc_pkg::rhcc_in_t  word;
    bit                  known;
    rhcc_pkg::rhcc_out_t golden;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  rhcc_pkg::rhcc_in_t  in_word;
  logic                out_valid;
  rhcc_pkg::rhcc_out_t out_word;

  rhcc_pkg::rhcc_out_t pending_colors[$];   // converted words still to come out, oldest first
  stim_row_t           directed_rows[$];
  int                  mismatches = 0;

  rgb_hsv_color_converter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // free-running clock, period 20
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the converter hangs or drops words
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // color math, round to nearest with ties up
  // ---------------------------------------------------------------------------

  function automatic longint unsigned rounded_div(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  // expected result word for one input word
  function automatic rhcc_pkg::rhcc_out_t convert_color(rhcc_pkg::rhcc_in_t w);
    longint unsigned r, g, b, h, s, v;
    longint unsigned mx, mn, c, num, sector, frac, ms, p, q, t;
    rhcc_pkg::rhcc_out_t res;
    res = '0;
    if (w.command == rhcc_pkg::CMD_HSV2RGB) begin
      h = w.hue_in;
      s = w.sat_in;
      v = w.val_in;
      if (s == 0) begin
        // no saturation: plain grey at the given value
        r = v;
        g = v;
        b = v;
      end else begin
        // hue past a full turn wraps around
        h      = h % TURN_STEPS;
        sector = h / HUE_STEPS;
        frac   = h % HUE_STEPS;
        ms     = CHAN_FULL * HUE_STEPS;
        p = rounded_div(v * (CHAN_FULL - s), CHAN_FULL);
        q = rounded_div(v * (ms - s * frac), ms);
        t = rounded_div(v * (ms - s * (HUE_STEPS - frac)), ms);
        case (sector)
          0: begin r = v; g = t; b = p; end
          1: begin r = q; g = v; b = p; end
          2: begin r = p; g = v; b = t; end
          3: begin r = p; g = q; b = v; end
          4: begin r = t; g = p; b = v; end
          default: begin r = v; g = p; b = q; end
        endcase
      end
      res.red_out   = r[CHAN_W-1:0];
      res.green_out = g[CHAN_W-1:0];
      res.blue_out  = b[CHAN_W-1:0];
    end else begin
      r = w.red_in;
      g = w.green_in;
      b = w.blue_in;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      // black gives zero saturation
      s = (mx == 0) ? 0 : rounded_div(c * CHAN_FULL, mx);
      if (c == 0) begin
        // grey has no hue
        h = 0;
      end else begin
        // ties on the largest channel go red, then green, then blue
        if (r >= g && r >= b)
          num = 6 * HUE_STEPS * c + HUE_STEPS * g - HUE_STEPS * b;
        else if (g >= b)
          num = 2 * HUE_STEPS * c + HUE_STEPS * b - HUE_STEPS * r;
        else
          num = 4 * HUE_STEPS * c + HUE_STEPS * r - HUE_STEPS * g;
        // a hue rounding up to a full turn comes back as zero
        h = rounded_div(num, c) % TURN_STEPS;
      end
      res.hue_out = h[HUE_W-1:0];
      res.sat_out = s[CHAN_W-1:0];
      res.val_out = mx[CHAN_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // word builders; the fields the command does not use get random junk
  // ---------------------------------------------------------------------------

  function automatic rhcc_pkg::rhcc_in_t rgb_word(int r, int g, int b);
    rhcc_pkg::rhcc_in_t w;
    w.command  = rhcc_pkg::CMD_RGB2HSV;
    w.red_in   = CHAN_W'(r);
    w.green_in = CHAN_W'(g);
    w.blue_in  = CHAN_W'(b);
    w.hue_in   = HUE_W'($urandom);
    w.sat_in   = CHAN_W'($urandom);
    w.val_in   = CHAN_W'($urandom);
    return w;
  endfunction

  function automatic rhcc_pkg::rhcc_in_t hsv_word(int h, int s, int v);
    rhcc_pkg::rhcc_in_t w;
    w.command  = rhcc_pkg::CMD_HSV2RGB;
    w.red_in   = CHAN_W'($urandom);
    w.green_in = CHAN_W'($urandom);
    w.blue_in  = CHAN_W'($urandom);
    w.hue_in   = HUE_W'(h);
    w.sat_in   = CHAN_W'(s);
    w.val_in   = CHAN_W'(v);
    return w;
  endfunction

  function automatic rhcc_pkg::rhcc_out_t hsv_result(int h, int s, int v);
    rhcc_pkg::rhcc_out_t res;
    res         = '0;
    res.hue_out = HUE_W'(h);
    res.sat_out = CHAN_W'(s);
    res.val_out = CHAN_W'(v);
    return res;
  endfunction

  function automatic rhcc_pkg::rhcc_out_t rgb_result(int r, int g, int b);
    rhcc_pkg::rhcc_out_t res;
    res           = '0;
    res.red_out   = CHAN_W'(r);
    res.green_out = CHAN_W'(g);
    res.blue_out  = CHAN_W'(b);
    return res;
  endfunction

  function automatic void add_row(rhcc_pkg::rhcc_in_t w, bit known,
                                  rhcc_pkg::rhcc_out_t golden);
    stim_row_t row;
    row.word   = w;
    row.known  = known;
    row.golden = golden;
    directed_rows.push_back(row);
  endfunction

  // channel value leaning toward the extremes
  function automatic int pick_chan();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 0;
    if (sel == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // idle cycles before a word: mostly none, some short, a few long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random word, with grey, black, zero saturation and wrapped hue mixed in
  function automatic rhcc_pkg::rhcc_in_t random_word();
    int sel;
    int lvl;
    sel = $urandom_range(0, 99);
    if (sel < 38) return rgb_word(pick_chan(), pick_chan(), pick_chan());
    if (sel < 45) begin
      lvl = pick_chan();
      return rgb_word(lvl, lvl, lvl);
    end
    if (sel < 50) begin
      // two channels tied, exercises the tie order and the full-turn wrap
      lvl = pick_chan();
      case ($urandom_range(0, 2))
        0: return rgb_word(pick_chan(), lvl, lvl);
        1: return rgb_word(lvl, lvl, pick_chan());
        default: return rgb_word(lvl, pick_chan(), lvl);
      endcase
    end
    if (sel < 82) return hsv_word($urandom_range(0, 1535), pick_chan(), pick_chan());
    if (sel < 90) return hsv_word($urandom_range(1536, 2047), pick_chan(), pick_chan());
    if (sel < 95) return hsv_word($urandom_range(0, 2047), 0, pick_chan());
    // all bits of every field free
    return rhcc_pkg::rhcc_in_t'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // driving: present a word, hold it until taken, log its expected result
  // ---------------------------------------------------------------------------

  task automatic issue_word(rhcc_pkg::rhcc_in_t w, rhcc_pkg::rhcc_out_t golden, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      in_word <= rhcc_pkg::rhcc_in_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    // taken at the first edge that sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    pending_colors.push_back(golden);
  endtask

  initial begin
    rhcc_pkg::rhcc_in_t w;
    int                 gap;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rgb to hsv: black, white, primaries, ties, wrap to zero hue, greys
    add_row(rgb_word(0, 0, 0), 1, hsv_result(0, 0, 0));
    add_row(rgb_word(255, 255, 255), 1, hsv_result(0, 0, 255));
    add_row(rgb_word(255, 0, 0), 1, hsv_result(0, 255, 255));
    add_row(rgb_word(0, 255, 0), 1, hsv_result(512, 255, 255));
    add_row(rgb_word(0, 0, 255), 1, hsv_result(1024, 255, 255));
    add_row(rgb_word(255, 255, 0), 1, hsv_result(256, 255, 255));
    add_row(rgb_word(7, 7, 7), 1, hsv_result(0, 0, 7));
    add_row(rgb_word(200, 50, 50), 0, '0);
    add_row(rgb_word(255, 0, 1), 0, '0);
    add_row(rgb_word(1, 0, 0), 0, '0);
    add_row(rgb_word(0, 1, 1), 0, '0);
    add_row(rgb_word(128, 64, 255), 0, '0);
    // hsv to rgb: zero saturation, sector edges, hue past a full turn, zero value
    add_row(hsv_word(700, 0, 123), 1, rgb_result(123, 123, 123));
    add_row(hsv_word(0, 0, 0), 1, rgb_result(0, 0, 0));
    add_row(hsv_word(0, 255, 255), 1, rgb_result(255, 0, 0));
    add_row(hsv_word(256, 255, 255), 1, rgb_result(255, 255, 0));
    add_row(hsv_word(512, 255, 255), 1, rgb_result(0, 255, 0));
    add_row(hsv_word(1024, 255, 255), 1, rgb_result(0, 0, 255));
    add_row(hsv_word(1536, 255, 255), 1, rgb_result(255, 0, 0));
    add_row(hsv_word(2047, 0, 255), 1, rgb_result(255, 255, 255));
    add_row(hsv_word(300, 255, 0), 1, rgb_result(0, 0, 0));
    add_row(hsv_word(1535, 255, 255), 0, '0);
    add_row(hsv_word(2047, 255, 255), 0, '0);
    add_row(hsv_word(100, 1, 1), 0, '0);
    add_row(hsv_word(900, 128, 200), 0, '0);

    // directed part goes back to back so the pipeline fills
    foreach (directed_rows[i])
      issue_word(directed_rows[i].word,
                 directed_rows[i].known ? directed_rows[i].golden
                                        : convert_color(directed_rows[i].word), 0);

    // random part, every fifth block of 40 words without idling
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w   = random_word();
      gap = ((i / 40) % 5 == 2) ? 0 : pick_gap();
      issue_word(w, convert_color(w), gap);
    end
    start <= 1'b0;

    // drain, then keep clocking to catch stray strobes
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result checking, one word per strobe
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [HUE_W-1:0] want, logic [HUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    rhcc_pkg::rhcc_out_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (out_valid !== 1'b1) begin
        $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
        mismatches++;
      end else if (pending_colors.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_word);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        check_field("red_out",   HUE_W'(want.red_out),   HUE_W'(out_word.red_out));
        check_field("green_out", HUE_W'(want.green_out), HUE_W'(out_word.green_out));
        check_field("blue_out",  HUE_W'(want.blue_out),  HUE_W'(out_word.blue_out));
        check_field("hue_out",   want.hue_out,           out_word.hue_out);
        check_field("sat_out",   HUE_W'(want.sat_out),   HUE_W'(out_word.sat_out));
        check_field("val_out",   HUE_W'(want.val_out),   HUE_W'(out_word.val_out));
      end
    end
  end

endmodule
